[hw/rtl/generation_tagged_key_table_core_assert.svh]
// Assertion macros used by the checker of the key table core.
// Depends on nothing; users supply clk and rst in scope.
`ifndef GENERATION_TAGGED_KEY_TABLE_CORE_ASSERT_SVH
`define GENERATION_TAGGED_KEY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GTKT_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("key table check failed");

// Next-cycle implication, disabled during reset.
`define GTKT_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("key table check failed");

`endif

[hw/rtl/gtkt_pkg.sv]
// Shared types and constants of the generation-tagged key table.
// Depends on nothing.
`default_nettype none

package gtkt_pkg;

  localparam int INDEX_BITS = 8;
  localparam int HANDLE_BITS = 32;
  localparam int GEN_BITS = HANDLE_BITS - INDEX_BITS;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_COUNT_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SET    = 2'd2,
    FUNC_GET    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    BK_ISSUE = 1'b0,
    BK_EXEC  = 1'b1
  } back_state_t;

  typedef struct packed {
    func_t                  func;
    logic                   idx_ok;
    logic [INDEX_BITS-1:0]  index_field;
    logic [GEN_BITS-1:0]    gen;
    logic [VALUE_BITS-1:0]  value;
  } q_entry_t;

endpackage

`default_nettype wire

[hw/rtl/gtkt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module gtkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/gtkt_front.sv]
// Front end: splits and checks each request's handle and queues it.
// Depends on gtkt_pkg.
`default_nettype none

module gtkt_front #(
  parameter int SLOT_COUNT = gtkt_pkg::SLOT_COUNT_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [1:0]                      func,
  input  wire logic [gtkt_pkg::HANDLE_BITS-1:0] key_handle,
  input  wire logic [gtkt_pkg::VALUE_BITS-1:0]  value_in,
  output logic                                 busy,
  output logic                                 q_valid,
  output gtkt_pkg::q_entry_t                   q_head,
  input  wire logic                            q_pop
);

  localparam int PTR_W = $clog2(gtkt_pkg::QUEUE_DEPTH);

  gtkt_pkg::q_entry_t entries [gtkt_pkg::QUEUE_DEPTH];
  gtkt_pkg::q_entry_t push_entry;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  always_comb begin
    push_entry.func        = gtkt_pkg::func_t'(func);
    push_entry.index_field = key_handle[gtkt_pkg::INDEX_BITS-1:0];
    push_entry.gen         = key_handle[gtkt_pkg::HANDLE_BITS-1:gtkt_pkg::INDEX_BITS];
    push_entry.value       = value_in;
    push_entry.idx_ok      = (push_entry.index_field != '0) &&
                             (push_entry.index_field <= gtkt_pkg::INDEX_BITS'(SLOT_COUNT)) &&
                             (push_entry.gen != '0);
  end

  assign busy    = (count == (PTR_W + 1)'(gtkt_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign pop     = q_pop && q_valid;
  assign q_head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gtkt_back.sv]
// Back end: reads the slot stores, carries out one request and reports it.
// Depends on gtkt_pkg and gtkt_ram.
`default_nettype none

module gtkt_back #(
  parameter int SLOT_COUNT = gtkt_pkg::SLOT_COUNT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire gtkt_pkg::q_entry_t               q_head,
  output logic                                  q_pop,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [gtkt_pkg::HANDLE_BITS-1:0]      new_handle,
  output logic [gtkt_pkg::VALUE_BITS-1:0]       value_out
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int GEN_BITS = gtkt_pkg::GEN_BITS;
  localparam int VALUE_BITS = gtkt_pkg::VALUE_BITS;
  localparam int STORE_W = GEN_BITS + VALUE_BITS;

  gtkt_pkg::back_state_t state;
  gtkt_pkg::back_state_t state_next;
  gtkt_pkg::q_entry_t    op;
  logic [SLOT_W-1:0]     slot;
  logic                  no_free;

  logic [SLOT_COUNT-1:0] in_use;
  logic [SLOT_COUNT-1:0] gen_valid;
  logic [SLOT_COUNT-1:0] store_valid;

  logic [SLOT_W-1:0]     free_slot;
  logic                  free_found;
  logic [SLOT_W-1:0]     head_slot;
  logic [SLOT_W-1:0]     issue_slot;
  logic [SLOT_W-1:0]     rd_addr;

  logic [GEN_BITS-1:0]   gen_rdata;
  logic [STORE_W-1:0]    store_rdata;
  logic [GEN_BITS-1:0]   gen_cur;
  logic [GEN_BITS-1:0]   gen_inc;
  logic [GEN_BITS-1:0]   st_gen;
  logic                  current;

  logic                  gen_we;
  logic                  store_we;
  logic                  use_set;
  logic                  use_clr;
  gtkt_pkg::status_t     res_status;
  logic [gtkt_pkg::HANDLE_BITS-1:0] res_handle;
  logic [VALUE_BITS-1:0] res_value;

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_slot  = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign head_slot  = SLOT_W'(q_head.index_field - gtkt_pkg::INDEX_BITS'(1));
  assign issue_slot = (q_head.func == gtkt_pkg::FUNC_CREATE) ? free_slot : head_slot;
  assign rd_addr    = (state == gtkt_pkg::BK_ISSUE) ? issue_slot : slot;

  gtkt_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (slot),
    .wdata (gen_inc),
    .raddr (rd_addr),
    .rdata (gen_rdata)
  );

  gtkt_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SLOT_COUNT)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (slot),
    .wdata ({op.gen, op.value}),
    .raddr (rd_addr),
    .rdata (store_rdata)
  );

  assign gen_cur = gen_valid[slot] ? gen_rdata : '0;
  assign st_gen  = store_valid[slot] ? store_rdata[STORE_W-1:VALUE_BITS] : '0;
  assign current = op.idx_ok && in_use[slot] && (gen_cur == op.gen);

  always_comb begin
    gen_inc = gen_cur + GEN_BITS'(1);
    if (gen_inc == '0) begin
      gen_inc = GEN_BITS'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gtkt_pkg::BK_ISSUE: begin
        if (q_valid) begin
          state_next = gtkt_pkg::BK_EXEC;
        end
      end
      gtkt_pkg::BK_EXEC: begin
        state_next = gtkt_pkg::BK_ISSUE;
      end
      default: begin
        state_next = gtkt_pkg::BK_ISSUE;
      end
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    gen_we     = 1'b0;
    store_we   = 1'b0;
    use_set    = 1'b0;
    use_clr    = 1'b0;
    res_status = gtkt_pkg::ST_INVALID;
    res_handle = '0;
    res_value  = '0;
    case (state)
      gtkt_pkg::BK_ISSUE: begin
        q_pop = q_valid;
      end
      gtkt_pkg::BK_EXEC: begin
        case (op.func)
          gtkt_pkg::FUNC_CREATE: begin
            if (no_free) begin
              res_status = gtkt_pkg::ST_FULL;
            end else begin
              gen_we     = 1'b1;
              use_set    = 1'b1;
              res_status = gtkt_pkg::ST_OK;
              res_handle = {gen_inc,
                            gtkt_pkg::INDEX_BITS'(slot) + gtkt_pkg::INDEX_BITS'(1)};
            end
          end
          gtkt_pkg::FUNC_DELETE: begin
            if (current) begin
              use_clr    = 1'b1;
              res_status = gtkt_pkg::ST_OK;
            end
          end
          gtkt_pkg::FUNC_SET: begin
            if (current) begin
              store_we   = 1'b1;
              res_status = gtkt_pkg::ST_OK;
            end
          end
          gtkt_pkg::FUNC_GET: begin
            if (op.idx_ok && (st_gen == op.gen)) begin
              res_status = gtkt_pkg::ST_OK;
              res_value  = store_rdata[VALUE_BITS-1:0];
            end
          end
          default: begin
            res_status = gtkt_pkg::ST_INVALID;
          end
        endcase
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op      <= q_head;
      slot    <= issue_slot;
      no_free <= !free_found;
    end
    status     <= res_status;
    new_handle <= res_handle;
    value_out  <= res_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gtkt_pkg::BK_ISSUE;
      done        <= 1'b0;
      in_use      <= '0;
      gen_valid   <= '0;
      store_valid <= '0;
    end else begin
      state <= state_next;
      done  <= (state == gtkt_pkg::BK_EXEC);
      if (use_set) begin
        in_use[slot]    <= 1'b1;
        gen_valid[slot] <= 1'b1;
      end
      if (use_clr) begin
        in_use[slot] <= 1'b0;
      end
      if (store_we) begin
        store_valid[slot] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/generation_tagged_key_table_core.sv]
// Generation-tagged key table: a request is accepted when start is high and busy low.
// The back end carries each request through a store read, then an update, and takes
// no new request from the queue until that update is done; each result strobes done,
// and a two-entry request queue absorbs bursts of two.
// Synchronous reset clears the queue and the in-use, gen and store valid bits at once.
// Depends on gtkt_pkg, gtkt_front, gtkt_back and gtkt_ram.
`default_nettype none

module generation_tagged_key_table_core #(
  parameter int SLOT_COUNT = gtkt_pkg::SLOT_COUNT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [1:0]                       func,
  input  wire logic [gtkt_pkg::HANDLE_BITS-1:0] key_handle,
  input  wire logic [gtkt_pkg::VALUE_BITS-1:0]  value_in,
  output logic                                  busy,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [gtkt_pkg::HANDLE_BITS-1:0]      new_handle,
  output logic [gtkt_pkg::VALUE_BITS-1:0]       value_out
);

  logic               q_valid;
  logic               q_pop;
  gtkt_pkg::q_entry_t q_head;

  gtkt_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .key_handle (key_handle),
    .value_in   (value_in),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  gtkt_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .done       (done),
    .status     (status),
    .new_handle (new_handle),
    .value_out  (value_out)
  );

endmodule

`default_nettype wire

[hw/rtl/gtkt_checker.sv]
// Port-level checker for the key table core, bound to the top level.
// Depends on gtkt_pkg and the assertion macro header.
`default_nettype none

`include "generation_tagged_key_table_core_assert.svh"

module gtkt_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             start,
  input wire logic [1:0]                       func,
  input wire logic [gtkt_pkg::HANDLE_BITS-1:0] key_handle,
  input wire logic [gtkt_pkg::VALUE_BITS-1:0]  value_in,
  input wire logic                             busy,
  input wire logic                             done,
  input wire logic [1:0]                       status,
  input wire logic [gtkt_pkg::HANDLE_BITS-1:0] new_handle,
  input wire logic [gtkt_pkg::VALUE_BITS-1:0]  value_out
);

  `GTKT_ASSERT_IMP(a_status_code, done, (status == gtkt_pkg::ST_OK) || (status == gtkt_pkg::ST_INVALID) || (status == gtkt_pkg::ST_FULL))
  `GTKT_ASSERT_IMP(a_fail_zero, done && (status != gtkt_pkg::ST_OK), (new_handle == '0) && (value_out == '0))
  `GTKT_ASSERT_IMP(a_handle_form, done && (new_handle != '0), (status == gtkt_pkg::ST_OK) && (new_handle[gtkt_pkg::INDEX_BITS-1:0] != '0) && (new_handle[gtkt_pkg::HANDLE_BITS-1:gtkt_pkg::INDEX_BITS] != '0) && (value_out == '0))
  `GTKT_ASSERT_NXT(a_result_spacing, done, !done)

endmodule

bind generation_tagged_key_table_core gtkt_checker u_gtkt_checker (.*);

`default_nettype wire
